@@ rtl/glyph_text_rasterizer_top_assert.svh @@
// Assertion macros used by the checker of the glyph rasteriser.
`ifndef GLYPH_TEXT_RASTERIZER_TOP_ASSERT_SVH
`define GLYPH_TEXT_RASTERIZER_TOP_ASSERT_SVH

// Implication checked in the same cycle, with reset masking.
`define GTR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("glyph rasteriser check failed");

// Implication checked in the next cycle, with reset masking.
`define GTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("glyph rasteriser check failed");

`endif

@@ rtl/gtr_pkg.sv @@
package gtr_pkg;

    // Printable character range of the font and the substitute character.
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;
    localparam logic [7:0] CHAR_SUBST = 8'h3F;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_CHARS = 95;
    localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;

    // Column counter value while the trailing gap rectangle is emitted.
    localparam logic [2:0] GAP_COL      = 3'(GLYPH_COLS);
    localparam logic [2:0] LAST_COL     = 3'(GLYPH_COLS - 1);
    localparam logic [2:0] LAST_ROW     = 3'(GLYPH_ROWS - 1);

    typedef logic [GLYPH_BITS-1:0] t_glyph;
    typedef logic [6:0]            t_glyph_idx;

    // Font ROM: five column bytes per character, column 0 in the top byte.
    // Bit r of a column byte lights row r.
    localparam logic [39:0] FONT_ROM [GLYPH_CHARS] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h085454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    // Repack a character into cell order: bit col*7+row is the cell colour select.
    // Rows 0 to 6 of column c sit in the low seven bits of its column byte.
    function automatic t_glyph glyph_bits(input t_glyph_idx idx);
        logic [39:0] cols;
        t_glyph      bits;
        cols = FONT_ROM[idx];
        for (int c = 0; c < GLYPH_COLS; c++) begin
            bits[c*GLYPH_ROWS +: GLYPH_ROWS] = cols[38 - 8*c -: GLYPH_ROWS];
        end
        return bits;
    endfunction

endpackage

@@ rtl/glyph_text_rasterizer_top.sv @@
// Turns text into rectangle-fill commands for a 5x7 font. An item with i_first high starts
// a string and latches position, colours and scale; each drawable character then yields 35
// cell rectangles (column by column, rows within a column) plus a background gap rectangle
// when it fits on screen, one rectangle per cycle from the output register while the output
// is not stalled. Characters that draw nothing (stopped string, zero scale, equal colours,
// screen overflow) produce no rectangles and leave the cell generator idle. The next item
// is accepted in the cycle the final rectangle of the current one is produced, so characters
// follow each other without gaps; the cell generator is the pacing unit.
module glyph_text_rasterizer_top
    import gtr_pkg::*;
#(
    parameter int SCREEN_WIDTH = 160
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_first,
    input  logic [9:0]  i_start_x,
    input  logic [9:0]  i_start_y,
    input  logic [15:0] i_fg_color,
    input  logic [15:0] i_bg_color,
    input  logic [3:0]  i_scale,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_rect_x,
    output logic [10:0] o_rect_y,
    output logic [3:0]  o_rect_w,
    output logic [6:0]  o_rect_h,
    output logic [15:0] o_rect_color,
    output logic        o_last
);

    localparam logic [11:0] WIDTH_LIMIT = 12'(SCREEN_WIDTH);

    // String state.
    logic [10:0] r_cursor_x, n_cursor_x;
    logic [9:0]  r_text_y;
    logic [15:0] r_fore_color, r_back_color;
    logic [3:0]  r_pixel_scale;
    logic        r_stopped, n_stopped;

    // Cell generator.
    logic        r_busy, n_busy;
    logic [2:0]  r_col, n_col;
    logic [2:0]  r_row, n_row;
    logic [10:0] r_gx, n_gx;
    logic [10:0] r_gy, n_gy;
    logic [9:0]  r_ty, n_ty;
    logic [3:0]  r_s, n_s;
    logic [6:0]  r_s7, n_s7;
    logic [15:0] r_fg, n_fg;
    logic [15:0] r_bg, n_bg;
    t_glyph      r_glyph, n_glyph;
    logic        r_gap, n_gap;

    // Output register.
    logic        r_ovalid, n_ovalid;
    logic [10:0] r_rx, n_rx;
    logic [10:0] r_ry, n_ry;
    logic [3:0]  r_rw, n_rw;
    logic [6:0]  r_rh, n_rh;
    logic [15:0] r_rc, n_rc;
    logic        r_rl, n_rl;

    logic        accept;
    logic [10:0] e_cx;
    logic [9:0]  e_ty;
    logic [15:0] e_fg, e_bg;
    logic [3:0]  e_s;
    logic        e_stopped;
    logic [6:0]  s5, s6, s7;
    logic [11:0] end5, end6;
    logic        draw_ok, over, emit;
    logic        code_ok;
    t_glyph_idx  glyph_idx;
    logic        gen_step, in_gap, gen_final;

    // Values in force for this item, taking a string start into account.
    always_comb begin
        e_cx      = i_first ? {1'b0, i_start_x} : r_cursor_x;
        e_ty      = i_first ? i_start_y : r_text_y;
        e_fg      = i_first ? i_fg_color : r_fore_color;
        e_bg      = i_first ? i_bg_color : r_back_color;
        e_s       = i_first ? i_scale : r_pixel_scale;
        e_stopped = i_first ? 1'b0 : r_stopped;
    end

    // Screen-edge tests and cursor advance.
    always_comb begin
        s5      = 7'({e_s, 2'b00}) + 7'(e_s);
        s6      = s5 + 7'(e_s);
        s7      = s6 + 7'(e_s);
        end5    = 12'(e_cx) + 12'(s5);
        end6    = 12'(e_cx) + 12'(s6);
        draw_ok = !e_stopped && (e_s != 4'd0);
        over    = end5 > WIDTH_LIMIT;
        emit    = draw_ok && !over && (e_fg != e_bg);
    end

    // Character lookup with substitution of unprintable codes.
    always_comb begin
        code_ok   = (i_char_code >= CHAR_FIRST) && (i_char_code <= CHAR_LAST);
        glyph_idx = code_ok ? 7'(i_char_code - CHAR_FIRST) : 7'(CHAR_SUBST - CHAR_FIRST);
    end

    // Generator handshake: the next item may enter as the final rectangle leaves.
    always_comb begin
        gen_step  = r_busy && (!r_ovalid || !i_stall);
        in_gap    = (r_col == GAP_COL);
        gen_final = in_gap || ((r_col == LAST_COL) && (r_row == LAST_ROW) && !r_gap);
        o_stall   = r_busy && !(gen_step && gen_final);
        accept    = i_valid && !o_stall;
    end

    // Next string state.
    always_comb begin
        n_cursor_x = r_cursor_x;
        n_stopped  = r_stopped;
        if (accept) begin
            n_stopped  = e_stopped || ((e_s != 4'd0) && over);
            n_cursor_x = (draw_ok && !over) ? end6[10:0] : e_cx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x    <= '0;
            r_text_y      <= '0;
            r_fore_color  <= '0;
            r_back_color  <= '0;
            r_pixel_scale <= '0;
            r_stopped     <= 1'b1;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_stopped  <= n_stopped;
            if (accept && i_first) begin
                r_text_y      <= i_start_y;
                r_fore_color  <= i_fg_color;
                r_back_color  <= i_bg_color;
                r_pixel_scale <= i_scale;
            end
        end
    end

    // Next generator state: load on a drawing item, else walk the cells.
    always_comb begin
        n_busy  = r_busy;
        n_col   = r_col;
        n_row   = r_row;
        n_gx    = r_gx;
        n_gy    = r_gy;
        n_ty    = r_ty;
        n_s     = r_s;
        n_s7    = r_s7;
        n_fg    = r_fg;
        n_bg    = r_bg;
        n_glyph = r_glyph;
        n_gap   = r_gap;
        if (gen_step) begin
            n_glyph = r_glyph >> 1;
            if (r_row == LAST_ROW) begin
                n_row = '0;
                n_col = r_col + 3'd1;
                n_gx  = r_gx + 11'(r_s);
                n_gy  = {1'b0, r_ty};
            end else begin
                n_row = r_row + 3'd1;
                n_gy  = r_gy + 11'(r_s);
            end
            if (gen_final) begin
                n_busy = 1'b0;
            end
        end
        if (accept && emit) begin
            n_busy  = 1'b1;
            n_col   = '0;
            n_row   = '0;
            n_gx    = e_cx;
            n_gy    = {1'b0, e_ty};
            n_ty    = e_ty;
            n_s     = e_s;
            n_s7    = s7;
            n_fg    = e_fg;
            n_bg    = e_bg;
            n_glyph = glyph_bits(glyph_idx);
            n_gap   = end6 <= WIDTH_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col   <= n_col;
        r_row   <= n_row;
        r_gx    <= n_gx;
        r_gy    <= n_gy;
        r_ty    <= n_ty;
        r_s     <= n_s;
        r_s7    <= n_s7;
        r_fg    <= n_fg;
        r_bg    <= n_bg;
        r_glyph <= n_glyph;
        r_gap   <= n_gap;
    end

    // Next output register contents: a cell, or the gap at the end.
    always_comb begin
        n_ovalid = r_ovalid && i_stall;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_rw     = r_rw;
        n_rh     = r_rh;
        n_rc     = r_rc;
        n_rl     = r_rl;
        if (gen_step) begin
            n_ovalid = 1'b1;
            n_rx     = r_gx;
            n_rw     = r_s;
            n_rl     = gen_final;
            if (in_gap) begin
                n_ry = {1'b0, r_ty};
                n_rh = r_s7;
                n_rc = r_bg;
            end else begin
                n_ry = r_gy;
                n_rh = 7'(r_s);
                n_rc = r_glyph[0] ? r_fg : r_bg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx <= n_rx;
        r_ry <= n_ry;
        r_rw <= n_rw;
        r_rh <= n_rh;
        r_rc <= n_rc;
        r_rl <= n_rl;
    end

    assign o_valid      = r_ovalid;
    assign o_rect_x     = r_rx;
    assign o_rect_y     = r_ry;
    assign o_rect_w     = r_rw;
    assign o_rect_h     = r_rh;
    assign o_rect_color = r_rc;
    assign o_last       = r_rl;

endmodule

@@ rtl/gtr_checker.sv @@
`include "glyph_text_rasterizer_top_assert.svh"

// Port-level checks on the rectangle stream.
module gtr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [10:0] o_rect_x,
    input logic [10:0] o_rect_y,
    input logic [3:0]  o_rect_w,
    input logic [6:0]  o_rect_h,
    input logic [15:0] o_rect_color,
    input logic        o_last
);

    // A stalled rectangle stays in place.
    `GTR_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_rect_x) && $stable(o_rect_y) && $stable(o_rect_color) && $stable(o_last))

    // Every rectangle is either a square cell or a gap seven cells high.
    `GTR_ASSERT_NOW(a_rect_shape, o_valid, (o_rect_w != 4'd0) && ((o_rect_h == 7'(o_rect_w)) || (o_rect_h == 7'(o_rect_w) * 7'd7)))

    // The tall gap rectangle always closes its character.
    `GTR_ASSERT_NOW(a_gap_last, o_valid && (o_rect_h != 7'(o_rect_w)), o_last)

    // Within a character the rectangles follow without a hole.
    `GTR_ASSERT_NEXT(a_no_hole, o_valid && !i_stall && !o_last, o_valid)

endmodule

bind glyph_text_rasterizer_top gtr_checker u_gtr_checker (.*);

@@ verif/glyph_text_rasterizer_top_test.sv @@
`timescale 1ns / 1ps

module glyph_text_rasterizer_top_test
    import gtr_pkg::*;
();

    localparam int SCREEN_W    = 160;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_LIMIT = 50000;
    localparam int TAIL_CYCLES = 80;

    // Font columns, column 0 in the top byte; bit r of a column byte lights row r.
    localparam logic [39:0] FONT_COLUMNS [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h085454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [3:0]  w;
        logic [6:0]  h;
        logic [15:0] color;
        logic        last;
    } t_rect;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_code  = '0;
    logic        i_first      = 1'b0;
    logic [9:0]  i_start_x    = '0;
    logic [9:0]  i_start_y    = '0;
    logic [15:0] i_fg_color   = '0;
    logic [15:0] i_bg_color   = '0;
    logic [3:0]  i_scale      = '0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [10:0] o_rect_x;
    logic [10:0] o_rect_y;
    logic [3:0]  o_rect_w;
    logic [6:0]  o_rect_h;
    logic [15:0] o_rect_color;
    logic        o_last;

    // Text state as the block should hold it.
    logic [10:0] st_cursor  = '0;
    logic [9:0]  st_text_y  = '0;
    logic [15:0] st_fore    = '0;
    logic [15:0] st_back    = '0;
    logic [3:0]  st_scale   = '0;
    logic        st_stopped = 1'b1;

    t_rect expected_rects [$];
    t_rect want;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int mismatches    = 0;
    int rects_checked = 0;
    int chars_sent    = 0;
    int chars_drawn   = 0;

    glyph_text_rasterizer_top #(
        .SCREEN_WIDTH(SCREEN_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_first     (i_first),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_fg_color  (i_fg_color),
        .i_bg_color  (i_bg_color),
        .i_scale     (i_scale),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rect_x    (o_rect_x),
        .o_rect_y    (o_rect_y),
        .o_rect_w    (o_rect_w),
        .o_rect_h    (o_rect_h),
        .o_rect_color(o_rect_color),
        .o_last      (o_last)
    );

    // Clock generation.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a run that never completes is a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d rectangles outstanding",
                 CYCLE_LIMIT, expected_rects.size());
        $display("** glyph_text_rasterizer_top: FAILED **");
        $finish;
    end

    // Queue one expected rectangle.
    task automatic add_rect(input int x, input int y, input int w, input int h,
                            input logic [15:0] color, input logic is_last);
        t_rect r;
        r.x     = 11'(x);
        r.y     = 11'(y);
        r.w     = 4'(w);
        r.h     = 7'(h);
        r.color = color;
        r.last  = is_last;
        expected_rects.push_back(r);
    endtask

    // Work out the rectangles one character should produce and update the text state.
    task automatic raster_char(input logic [7:0] code, input logic is_first,
                               input logic [9:0] sx, input logic [9:0] sy,
                               input logic [15:0] fg, input logic [15:0] bg,
                               input logic [3:0] sc, output int count);
        int          s;
        int          cx;
        logic [7:0]  glyph_code;
        logic [39:0] cols;
        logic [7:0]  col_bits;
        logic        gap_fits;
        count = 0;
        if (is_first) begin
            st_cursor  = {1'b0, sx};
            st_text_y  = sy;
            st_fore    = fg;
            st_back    = bg;
            st_scale   = sc;
            st_stopped = 1'b0;
        end
        s  = int'(st_scale);
        cx = int'(st_cursor);
        if (st_stopped || s == 0) return;
        // A character that would cross the right edge ends the string.
        if (cx + 5 * s > SCREEN_W) begin
            st_stopped = 1'b1;
            return;
        end
        glyph_code = (code < CHAR_FIRST || code > CHAR_LAST) ? CHAR_SUBST : code;
        if (st_fore != st_back) begin
            cols     = FONT_COLUMNS[glyph_code - CHAR_FIRST];
            gap_fits = (cx + 6 * s <= SCREEN_W);
            for (int col = 0; col < 5; col++) begin
                col_bits = cols[39 - 8 * col -: 8];
                for (int row = 0; row < 7; row++) begin
                    add_rect(cx + col * s, int'(st_text_y) + row * s, s, s,
                             col_bits[row] ? st_fore : st_back,
                             !gap_fits && col == 4 && row == 6);
                    count++;
                end
            end
            if (gap_fits) begin
                add_rect(cx + 5 * s, int'(st_text_y), s, 7 * s, st_back, 1'b1);
                count++;
            end
        end
        st_cursor = 11'(cx + 6 * s);
    endtask

    // Offer one character item, wait until it is taken, then predict its rectangles.
    task automatic send_char(input logic [7:0] code, input logic is_first,
                             input logic [9:0] sx, input logic [9:0] sy,
                             input logic [15:0] fg, input logic [15:0] bg,
                             input logic [3:0] sc);
        int produced;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= code;
        i_first     <= is_first;
        i_start_x   <= sx;
        i_start_y   <= sy;
        i_fg_color  <= fg;
        i_bg_color  <= bg;
        i_scale     <= sc;
        do @(posedge i_clk); while (o_stall);
        raster_char(code, is_first, sx, sy, fg, bg, sc, produced);
        chars_sent++;
        if (produced > 0) chars_drawn++;
    endtask

    // Hold the sender off until every expected rectangle has come back.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_rects.size() != 0);
    endtask

    // Result checking and receiver back-pressure.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rects.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected rectangle: x=%0d y=%0d w=%0d h=%0d c=%h last=%b",
                             o_rect_x, o_rect_y, o_rect_w, o_rect_h, o_rect_color, o_last);
            end else begin
                want = expected_rects.pop_front();
                rects_checked++;
                if (o_rect_x !== want.x || o_rect_y !== want.y || o_rect_w !== want.w ||
                    o_rect_h !== want.h || o_rect_color !== want.color ||
                    o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("rect %0d got x=%0d y=%0d w=%0d h=%0d c=%h last=%b",
                                 rects_checked, o_rect_x, o_rect_y, o_rect_w, o_rect_h,
                                 o_rect_color, o_last);
                        $display("     expected x=%0d y=%0d w=%0d h=%0d c=%h last=%b",
                                 want.x, want.y, want.w, want.h, want.color, want.last);
                    end
                end
            end
        end
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Characters before any string has been started draw nothing.
    task automatic test_before_string();
        send_char("A", 1'b0, 10'd0, 10'd0, 16'hFFFF, 16'h0000, 4'd1);
        send_char(8'hFF, 1'b0, 10'h3FF, 10'h3FF, 16'hFFFF, 16'hFFFF, 4'hF);
    endtask

    // Ends of the printable range and codes replaced by the question mark.
    task automatic test_char_codes();
        send_char("A", 1'b1, 10'd0, 10'd0, 16'hFFFF, 16'h0000, 4'd1);
        send_char(8'h20, 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char(8'h7E, 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char(8'h1F, 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char(8'h7F, 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char(8'h00, 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char(8'hFF, 1'b0, 10'h3FF, 10'h3FF, 16'hFFFF, 16'hFFFF, 4'hF);
    endtask

    // Largest scale at the bottom row, overflow, and a stopped string.
    task automatic test_scale_limits();
        send_char("#", 1'b1, 10'd0, 10'h3FF, 16'h0000, 16'hFFFF, 4'hF);
        send_char("W", 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char("M", 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char("x", 1'b1, 10'd155, 10'd0, 16'hF800, 16'h07E0, 4'd1);
        send_char("y", 1'b1, 10'h3FF, 10'd20, 16'h001F, 16'hFFE0, 4'd1);
    endtask

    // A zero scale draws nothing until a new string sets a usable one.
    task automatic test_zero_scale();
        send_char("8", 1'b1, 10'd10, 10'd10, 16'h1234, 16'h4321, 4'd0);
        send_char("8", 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char("8", 1'b1, 10'd10, 10'd10, 16'h1234, 16'h4321, 4'd3);
    endtask

    // Equal colours draw nothing, while the cursor still moves towards the edge.
    task automatic test_equal_colours();
        send_char("@", 1'b1, 10'd100, 10'd5, 16'h1234, 16'h1234, 4'd10);
        send_char("@", 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
        send_char("@", 1'b1, 10'd0, 10'd5, 16'hABCD, 16'hABCD, 4'd2);
    endtask

    // The gap is dropped when it would cross the edge, and kept when it just fits.
    task automatic test_gap_omitted();
        send_char("Q", 1'b1, 10'd150, 10'd30, 16'hAAAA, 16'h5555, 4'd2);
        send_char("Q", 1'b1, 10'd148, 10'd30, 16'h5555, 16'hAAAA, 4'd2);
        send_char("Q", 1'b0, 10'd0, 10'd0, 16'd0, 16'd0, 4'd0);
    endtask

    // Scale weighted towards small values, with some large and zero.
    function automatic logic [3:0] random_scale();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 4'($urandom_range(2, 1));
        if (r < 80) return 4'($urandom_range(6, 3));
        if (r < 95) return 4'($urandom_range(15, 7));
        return 4'd0;
    endfunction

    function automatic logic [7:0] random_code();
        if ($urandom_range(4) == 0) return 8'($urandom);
        return 8'($urandom_range(126, 32));
    endfunction

    // Mostly well-formed strings with random content, the rest single noise items.
    task automatic random_strings(input int target);
        int          sent_start;
        int          pick;
        int          len;
        logic [9:0]  sx;
        logic [15:0] fg;
        logic [15:0] bg;
        sent_start = chars_sent;
        wait_for_drain();
        while (chars_sent - sent_start < target) begin
            pick = $urandom_range(99);
            if (pick < 4) wait_for_drain();
            if (pick < 88) begin
                sx  = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(159));
                fg  = 16'($urandom);
                bg  = ($urandom_range(11) == 0) ? fg : 16'($urandom);
                len = $urandom_range(9, 1);
                send_char(random_code(), 1'b1, sx, 10'($urandom), fg, bg, random_scale());
                for (int i = 1; i < len; i++) begin
                    send_char(random_code(), 1'b0, 10'($urandom), 10'($urandom),
                              16'($urandom), 16'($urandom), 4'($urandom));
                end
            end else begin
                send_char(8'($urandom), 1'($urandom), 10'($urandom), 10'($urandom),
                          16'($urandom), 16'($urandom), 4'($urandom));
            end
        end
    endtask

    // Three idling mixes: sender light, then receiver light, then none.
    task automatic test_random_traffic();
        tx_idle_pct = 10;
        rx_idle_pct = 57;
        random_strings(129);
        tx_idle_pct = 57;
        rx_idle_pct = 10;
        random_strings(129);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_strings(129);
    endtask

    // Drain, settle, report.
    task automatic finish_run();
        int waited;
        i_valid <= 1'b0;
        waited = 0;
        while (expected_rects.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_rects.size() != 0) begin
            $display("%0d expected rectangles never arrived", expected_rects.size());
            mismatches += expected_rects.size();
        end
        $display("Sent %0d characters (%0d drawn) and checked %0d rectangles.",
                 chars_sent, chars_drawn, rects_checked);
        $display("Covered scales 0 to 15, substituted codes, overflow, colour ties, gap drop.");
        if (mismatches == 0) begin
            $display("** glyph_text_rasterizer_top: PASSED **");
        end else begin
            $display("** glyph_text_rasterizer_top: FAILED **");
        end
        $finish;
    endtask

    // Test sequence.
    initial begin
        tx_idle_pct = 10;
        rx_idle_pct = 57;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_before_string();
        test_char_codes();
        test_scale_limits();
        test_zero_scale();
        test_equal_colours();
        test_gap_omitted();
        test_random_traffic();
        finish_run();
    end

endmodule
